// ===== src/tsof_pkg.sv =====
// Shared widths and step codes for the Tustin second-order filter.
// No dependencies; used by tsof_mul, tsof_div and tustin_second_order_filter.
package tsof_pkg;

    localparam int DW      = 32;   // sample and coefficient width
    localparam int TW      = 16;   // time step width
    localparam int NUM_REGS = 6;
    localparam int IDXW    = 3;

    localparam int CW      = 72;   // discretized coefficient width
    localparam int CHUNK   = 36;   // coefficient half fed to the multiplier
    localparam int MA      = 33;   // multiplier operand a
    localparam int MB      = 37;   // multiplier operand b
    localparam int PW      = MA + MB;
    localparam int AW      = 104;  // numerator accumulator
    localparam int NW      = 108;  // divider datapath
    localparam int QW      = 34;   // quotient bits, top bit is overflow
    localparam int SW      = 4;    // step counter

    // register indexes
    localparam logic [IDXW-1:0] REG_NUM_S2 = 3'd0;
    localparam logic [IDXW-1:0] REG_NUM_S1 = 3'd1;
    localparam logic [IDXW-1:0] REG_NUM_S0 = 3'd2;
    localparam logic [IDXW-1:0] REG_DEN_S2 = 3'd3;
    localparam logic [IDXW-1:0] REG_DEN_S1 = 3'd4;
    localparam logic [IDXW-1:0] REG_DEN_S0 = 3'd5;

    // multiply sequence
    localparam logic [SW-1:0] STEP_K1   = 4'd0;   // dt*dt
    localparam logic [SW-1:0] STEP_Q    = 4'd1;
    localparam logic [SW-1:0] STEP_R    = 4'd2;
    localparam logic [SW-1:0] STEP_QD   = 4'd3;
    localparam logic [SW-1:0] STEP_RD   = 4'd4;
    localparam logic [SW-1:0] STEP_TAP  = 4'd5;   // first sample product
    localparam logic [SW-1:0] STEP_LAST = 4'd14;

endpackage

// ===== src/tsof_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on tsof_pkg.
module tsof_mul (
    input  logic                              aclk,
    input  logic signed [tsof_pkg::MA-1:0]    op_a,
    input  logic signed [tsof_pkg::MB-1:0]    op_b,
    output logic signed [tsof_pkg::PW-1:0]    product
);

    logic signed [tsof_pkg::PW-1:0] product_reg;

    always_ff @(posedge aclk) begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;

endmodule

// ===== src/tsof_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on tsof_pkg. Quotient top bit set means quotient >= 2^(QW-1).
module tsof_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tsof_pkg::NW-1:0]       dividend,
    input  logic [tsof_pkg::NW-1:0]       divisor,
    output logic                          done,
    output logic [tsof_pkg::QW-1:0]       quotient
);

    localparam int CNTW = $clog2(tsof_pkg::QW);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CNTW-1:0]            cnt_reg, cnt_next;
    logic [tsof_pkg::NW-1:0]    rem_reg, rem_next;
    logic [tsof_pkg::NW-1:0]    dsh_reg, dsh_next;
    logic [tsof_pkg::QW-1:0]    quo_reg, quo_next;

    always_comb begin
        logic ge;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        ge        = rem_reg >= dsh_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(tsof_pkg::QW - 1);
            rem_next  = dividend;
            dsh_next  = divisor << (tsof_pkg::QW - 1);
            quo_next  = '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[tsof_pkg::QW-2:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/tustin_second_order_filter.sv =====
// Tustin second-order filter: per-request bilinear discretization and biquad update.
// Each request runs 15 products on one shared multiplier, each an issue state and
// a wait state, with the coefficient state after the fifth product; then a divider
// load and bit-serial division until done. A zero time step goes straight to the
// output state, a zero denominator right after the coefficient state.
// One request at a time: s_ready is high only while idle, so a new request is
// taken only once the last result has been accepted. Synchronous active-low
// reset clears coefficients and filter history.
module tustin_second_order_filter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [tsof_pkg::IDXW-1:0]      cfg_index,
    input  logic [tsof_pkg::DW-1:0]        cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [tsof_pkg::DW-1:0] s_sample_in,
    input  logic [tsof_pkg::TW-1:0]        s_time_step,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [tsof_pkg::DW-1:0] m_sample_out,
    output logic                           m_stepped,
    output logic                           m_divide_fault
);

    localparam int DW = tsof_pkg::DW;
    localparam int CW = tsof_pkg::CW;
    localparam int AW = tsof_pkg::AW;
    localparam int NW = tsof_pkg::NW;
    localparam int QW = tsof_pkg::QW;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL_ISSUE, ST_MUL_WAIT, ST_COEF, ST_DIV_LOAD, ST_DIV_WAIT, ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic signed [DW-1:0] coef_reg [tsof_pkg::NUM_REGS];
    logic signed [DW-1:0] coef_next [tsof_pkg::NUM_REGS];
    logic signed [DW-1:0] u_reg, u_next, x1_reg, x1_next, x2_reg, x2_next;
    logic signed [DW-1:0] y1_reg, y1_next, y2_reg, y2_next;
    logic [tsof_pkg::TW-1:0] t_reg, t_next;
    logic [DW-1:0]        k1_reg, k1_next;
    logic signed [CW-1:0] q_reg, q_next, r_reg, r_next, qd_reg, qd_next, rd_reg, rd_next;
    logic signed [CW-1:0] cf_reg [5];
    logic signed [CW-1:0] cf_next [5];
    logic signed [CW-1:0] den_reg, den_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic [tsof_pkg::SW-1:0] step_reg, step_next;
    logic                 neg_reg, neg_next;
    logic                 m_valid_reg, m_valid_next;
    logic signed [DW-1:0] out_reg, out_next;
    logic                 stepped_reg, stepped_next;
    logic                 fault_reg, fault_next;

    logic signed [tsof_pkg::MA-1:0] op_a;
    logic signed [tsof_pkg::MB-1:0] op_b;
    logic signed [tsof_pkg::PW-1:0] product;
    logic                           div_start;
    logic [NW-1:0]                  div_n, div_d;
    logic                           div_done;
    logic [QW-1:0]                  div_q;

    tsof_mul u_mul (
        .aclk    (aclk),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (product)
    );

    tsof_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    // tap select for the sample products: two steps per tap, low half first
    logic [2:0]           tap;
    logic                 hi_half;
    logic signed [DW-1:0] tap_x;
    logic signed [CW-1:0] tap_c;

    always_comb begin
        hi_half = ~step_reg[0];
        case (step_reg)
            4'd5, 4'd6:   tap = 3'd0;
            4'd7, 4'd8:   tap = 3'd1;
            4'd9, 4'd10:  tap = 3'd2;
            4'd11, 4'd12: tap = 3'd3;
            default:      tap = 3'd4;
        endcase
        case (tap)
            3'd0:    tap_x = u_reg;
            3'd1:    tap_x = x1_reg;
            3'd2:    tap_x = x2_reg;
            3'd3:    tap_x = y1_reg;
            default: tap_x = y2_reg;
        endcase
        tap_c = cf_reg[tap];
    end

    always_comb begin
        case (step_reg)
            tsof_pkg::STEP_K1: begin
                op_a = {17'd0, t_reg};
                op_b = {21'd0, t_reg};
            end
            tsof_pkg::STEP_Q: begin
                op_a = tsof_pkg::MA'(coef_reg[tsof_pkg::REG_NUM_S1]);
                op_b = {21'd0, t_reg};
            end
            tsof_pkg::STEP_R: begin
                op_a = tsof_pkg::MA'(coef_reg[tsof_pkg::REG_NUM_S0]);
                op_b = {5'd0, k1_reg};
            end
            tsof_pkg::STEP_QD: begin
                op_a = tsof_pkg::MA'(coef_reg[tsof_pkg::REG_DEN_S1]);
                op_b = {21'd0, t_reg};
            end
            tsof_pkg::STEP_RD: begin
                op_a = tsof_pkg::MA'(coef_reg[tsof_pkg::REG_DEN_S0]);
                op_b = {5'd0, k1_reg};
            end
            default: begin
                op_a = tsof_pkg::MA'(tap_x);
                op_b = hi_half ? {tap_c[CW-1], tap_c[CW-1:tsof_pkg::CHUNK]}
                               : {1'b0, tap_c[tsof_pkg::CHUNK-1:0]};
            end
        endcase
    end

    always_comb begin
        logic signed [CW-1:0] p, pd, prod_c, den_c;
        logic signed [AW-1:0] term, an;
        logic [CW-1:0]        ad;
        logic [QW-1:0]        mag;
        state_next   = state_reg;
        for (int i = 0; i < tsof_pkg::NUM_REGS; i++) coef_next[i] = coef_reg[i];
        for (int i = 0; i < 5; i++) cf_next[i] = cf_reg[i];
        u_next = u_reg;  t_next = t_reg;
        x1_next = x1_reg; x2_next = x2_reg; y1_next = y1_reg; y2_next = y2_reg;
        k1_next = k1_reg; q_next = q_reg; r_next = r_reg; qd_next = qd_reg; rd_next = rd_reg;
        den_next = den_reg; acc_next = acc_reg; step_next = step_reg; neg_next = neg_reg;
        m_valid_next = m_valid_reg; out_next = out_reg;
        stepped_next = stepped_reg; fault_next = fault_reg;
        div_start = 1'b0;

        p      = CW'(coef_reg[tsof_pkg::REG_NUM_S2]) <<< 34;
        pd     = CW'(coef_reg[tsof_pkg::REG_DEN_S2]) <<< 34;
        prod_c = CW'(product);
        den_c  = pd + qd_reg + rd_reg;
        term   = AW'(product);
        if (hi_half) term = term <<< tsof_pkg::CHUNK;
        an     = acc_reg[AW-1] ? -acc_reg : acc_reg;
        ad     = den_reg[CW-1] ? CW'(-den_reg) : CW'(den_reg);
        div_n  = (NW'(an) << 1) + NW'(ad);
        div_d  = NW'(ad) << 1;
        mag    = div_q;

        if (cfg_wr_en && cfg_index < tsof_pkg::IDXW'(tsof_pkg::NUM_REGS)) begin
            coef_next[cfg_index] = cfg_wr_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    u_next = s_sample_in;
                    t_next = s_time_step;
                    if (s_time_step == '0) begin
                        out_next = y1_reg; stepped_next = 1'b0; fault_next = 1'b0;
                        m_valid_next = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        step_next  = tsof_pkg::STEP_K1;
                        state_next = ST_MUL_ISSUE;
                    end
                end
            end
            ST_MUL_ISSUE: state_next = ST_MUL_WAIT;
            ST_MUL_WAIT: begin
                unique case (step_reg)
                    tsof_pkg::STEP_K1: k1_next = product[DW-1:0];
                    tsof_pkg::STEP_Q:  q_next  = prod_c <<< 17;
                    tsof_pkg::STEP_R:  r_next  = prod_c;
                    tsof_pkg::STEP_QD: qd_next = prod_c <<< 17;
                    tsof_pkg::STEP_RD: rd_next = prod_c;
                    default: begin
                        // output taps enter with a minus sign
                        if (tap >= 3'd3) acc_next = acc_reg - term;
                        else             acc_next = acc_reg + term;
                    end
                endcase
                if (step_reg == tsof_pkg::STEP_RD) begin
                    state_next = ST_COEF;
                end else if (step_reg == tsof_pkg::STEP_LAST) begin
                    state_next = ST_DIV_LOAD;
                end else begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_MUL_ISSUE;
                end
            end
            ST_COEF: begin
                den_next = den_c;
                if (den_c == '0) begin
                    out_next = y1_reg; stepped_next = 1'b0; fault_next = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    cf_next[0] = p + q_reg + r_reg;
                    cf_next[1] = (r_reg <<< 1) - (p <<< 1);
                    cf_next[2] = p - q_reg + r_reg;
                    cf_next[3] = (rd_reg <<< 1) - (pd <<< 1);
                    cf_next[4] = pd - qd_reg + rd_reg;
                    acc_next   = '0;
                    step_next  = tsof_pkg::STEP_TAP;
                    state_next = ST_MUL_ISSUE;
                end
            end
            ST_DIV_LOAD: begin
                neg_next   = acc_reg[AW-1] ^ den_reg[CW-1];
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    // rounded magnitude, clamp to the signed range
                    if (neg_reg) begin
                        if (mag > (QW'(1) << (DW - 1))) out_next = {1'b1, {(DW-1){1'b0}}};
                        else                            out_next = -DW'(mag);
                    end else begin
                        if (mag > QW'({1'b0, {(DW-1){1'b1}}})) out_next = {1'b0, {(DW-1){1'b1}}};
                        else                                   out_next = DW'(mag);
                    end
                    x2_next = x1_reg; x1_next = u_reg;
                    y2_next = y1_reg; y1_next = out_next;
                    stepped_next = 1'b1; fault_next = 1'b0;
                    m_valid_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < tsof_pkg::NUM_REGS; i++) coef_reg[i] <= '0;
            x1_reg <= '0; x2_reg <= '0; y1_reg <= '0; y2_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < tsof_pkg::NUM_REGS; i++) coef_reg[i] <= coef_next[i];
            x1_reg <= x1_next; x2_reg <= x2_next; y1_reg <= y1_next; y2_reg <= y2_next;
        end
        for (int i = 0; i < 5; i++) cf_reg[i] <= cf_next[i];
        u_reg <= u_next; t_reg <= t_next; k1_reg <= k1_next;
        q_reg <= q_next; r_reg <= r_next; qd_reg <= qd_next; rd_reg <= rd_next;
        den_reg <= den_next; acc_reg <= acc_next; step_reg <= step_next; neg_reg <= neg_next;
        out_reg <= out_next; stepped_reg <= stepped_next; fault_reg <= fault_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_sample_out   = out_reg;
    assign m_stepped      = stepped_reg;
    assign m_divide_fault = fault_reg;

endmodule
